// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro expands to one labeled concurrent assertion, clocked on clk
// and switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// File: rtl/ssmix_pkg.sv
// ---------------------------------------------------------------------------
// ssmix_pkg
// Shared types and constants of the saturating stereo sample mixer.
// ---------------------------------------------------------------------------
package ssmix_pkg;

	// Source format codes
	localparam logic [1:0] FMT_STEREO = 2'd0;
	localparam logic [1:0] FMT_MONO   = 2'd1;
	localparam logic [1:0] FMT_VOLUME = 2'd2;
	localparam logic [1:0] FMT_SPARE  = 2'd3;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_ADD    = 2'd1;
	localparam logic [1:0] REG_VOL_L  = 2'd2;
	localparam logic [1:0] REG_VOL_R  = 2'd3;

	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;
	localparam int SRC_W        = 32;
	localparam int OUT_W        = 16;
	localparam int VOL_W        = 24;
	localparam int SAMPLE_SHIFT = 8;
	localparam int VOLUME_SHIFT = 10;

	// Derived widths
	localparam int WIDE_W = SRC_W - SAMPLE_SHIFT;        // shifted wide sample
	localparam int VEFF_W = VOL_W - VOLUME_SHIFT;        // effective volume
	localparam int PROD_W = OUT_W + VEFF_W + 1;          // signed product
	localparam int SUM_W  = WIDE_W + 1;                  // scaled + prior

	localparam logic signed [OUT_W-1:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [OUT_W-1:0] SAT_MIN = -16'sh8000;

	// Configuration register contents
	typedef struct packed {
		logic [1:0]       fmt;
		logic             add;
		logic [VOL_W-1:0] vol_l;
		logic [VOL_W-1:0] vol_r;
	} cfg_regs_t;

	// Per-channel datapath control
	typedef struct packed {
		logic vol_mode;
		logic add_mode;
	} chan_ctrl_t;

endpackage

// File: rtl/ssmix_apb.sv
// ---------------------------------------------------------------------------
// ssmix_apb
// APB register file holding source format, add mode and channel volumes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ssmix_apb (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ssmix_pkg::ADDR_W-1:0] paddr,
	input  logic [ssmix_pkg::DATA_W-1:0] pwdata,
	output logic [ssmix_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output ssmix_pkg::cfg_regs_t        cfg
);
	import ssmix_pkg::*;

	logic [1:0]       fmt_q;
	logic             add_q;
	logic [VOL_W-1:0] vol_l_q;
	logic [VOL_W-1:0] vol_r_q;
	logic             wr_en;
	logic [1:0]       reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_STEREO;
			add_q   <= 1'b0;
			vol_l_q <= '0;
			vol_r_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FORMAT: fmt_q   <= pwdata[1:0];
				REG_ADD:    add_q   <= pwdata[0];
				REG_VOL_L:  vol_l_q <= pwdata[VOL_W-1:0];
				REG_VOL_R:  vol_r_q <= pwdata[VOL_W-1:0];
				default:    fmt_q   <= fmt_q;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (reg_idx)
			REG_FORMAT: prdata = {{(DATA_W-2){1'b0}}, fmt_q};
			REG_ADD:    prdata = {{(DATA_W-1){1'b0}}, add_q};
			REG_VOL_L:  prdata = {{(DATA_W-VOL_W){1'b0}}, vol_l_q};
			REG_VOL_R:  prdata = {{(DATA_W-VOL_W){1'b0}}, vol_r_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.fmt   = fmt_q;
	assign cfg.add   = add_q;
	assign cfg.vol_l = vol_l_q;
	assign cfg.vol_r = vol_r_q;

	`ASSERT_CLK(a_fmt_write, wr_en && reg_idx == REG_FORMAT |=> fmt_q == $past(pwdata[1:0]), "format register write lost")
	`ASSERT_CLK(a_vol_hold, !wr_en |=> vol_l_q == $past(vol_l_q) && vol_r_q == $past(vol_r_q), "volume changed without a write")
	`ASSERT_CLK(a_rd_add, reg_idx == REG_ADD |-> prdata == DATA_W'(add_q), "add mode readback mismatch")

endmodule

// File: rtl/ssmix_chan.sv
// ---------------------------------------------------------------------------
// ssmix_chan
// One channel: wide shift or volume scale, optional prior add, saturation.
// ---------------------------------------------------------------------------
module ssmix_chan (
	input  logic signed [ssmix_pkg::SRC_W-1:0] sample,
	input  logic signed [ssmix_pkg::OUT_W-1:0] prior,
	input  logic        [ssmix_pkg::VOL_W-1:0] volume,
	input  ssmix_pkg::chan_ctrl_t              ctrl,
	output logic signed [ssmix_pkg::OUT_W-1:0] result
);
	import ssmix_pkg::*;

	logic signed [OUT_W-1:0]  samp16;
	logic signed [VEFF_W:0]   vol_eff;
	logic signed [PROD_W-1:0] prod;
	logic signed [WIDE_W-1:0] scaled;
	logic signed [SUM_W-1:0]  prior_ext;
	logic signed [SUM_W-1:0]  sum;
	logic                     fits;

	// Volume path: low 16 bits times volume with its fraction dropped
	assign samp16  = sample[OUT_W-1:0];
	assign vol_eff = {1'b0, volume[VOL_W-1:VOLUME_SHIFT]};
	assign prod    = samp16 * vol_eff;

	// Pick the volume product or the wide sample, both shifted down
	always_comb begin
		if (ctrl.vol_mode) begin
			scaled = WIDE_W'(prod >>> SAMPLE_SHIFT);
		end else begin
			scaled = sample[SRC_W-1:SAMPLE_SHIFT];
		end
	end

	// Add the prior sample in add mode
	assign prior_ext = ctrl.add_mode ? SUM_W'(prior) : '0;
	assign sum       = SUM_W'(scaled) + prior_ext;

	// Saturate: in range when every bit above the output sign matches it
	assign fits = (sum[SUM_W-1:OUT_W-1] == '0) || (sum[SUM_W-1:OUT_W-1] == '1);

	always_comb begin
		if (fits) begin
			result = sum[OUT_W-1:0];
		end else if (sum[SUM_W-1]) begin
			result = SAT_MIN;
		end else begin
			result = SAT_MAX;
		end
	end

endmodule

// File: rtl/saturating_stereo_sample_mixer.sv
// ---------------------------------------------------------------------------
// saturating_stereo_sample_mixer
// Stereo frame mixer: format conversion, volume, prior add, 16-bit saturation.
// ---------------------------------------------------------------------------
// Usage:
//   The source channel (src_valid / src_stall) takes one stereo frame per
//   item: src_left, src_right, prior_left, prior_right and end_of_block.
//   The result channel (out_valid / out_stall) gives one saturated 16-bit
//   frame per item, with block_last copied from end_of_block.
//   The APB port sets source format, add mode and the two volumes; write it
//   only while no item is in flight.
//   An accepted item moves through an input register, one pass through the
//   channel datapath (one 16x15 multiply, add, saturate) and the result
//   register, which drives out_valid. Throughput is one item per cycle while
//   out_stall is low, set by that single datapath pass.
//   While out_stall holds a result, the input register still takes one more
//   item; src_stall rises only when both registers are full and the output
//   is stalled.
//   Reset clears both valid flags and all configuration registers to zero
//   (stereo-wide format, replace mode, zero volume).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module saturating_stereo_sample_mixer (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ssmix_pkg::ADDR_W-1:0]      paddr,
	input  logic [ssmix_pkg::DATA_W-1:0]      pwdata,
	output logic [ssmix_pkg::DATA_W-1:0]      prdata,
	output logic                              pready,
	// source items
	input  logic                              src_valid,
	output logic                              src_stall,
	input  logic signed [ssmix_pkg::SRC_W-1:0] src_left,
	input  logic signed [ssmix_pkg::SRC_W-1:0] src_right,
	input  logic signed [ssmix_pkg::OUT_W-1:0] prior_left,
	input  logic signed [ssmix_pkg::OUT_W-1:0] prior_right,
	input  logic                              end_of_block,
	// result items
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [ssmix_pkg::OUT_W-1:0] out_left,
	output logic signed [ssmix_pkg::OUT_W-1:0] out_right,
	output logic                              block_last
);
	import ssmix_pkg::*;

	cfg_regs_t               cfg;
	chan_ctrl_t              ctrl;

	logic                    valid_s1;
	logic signed [SRC_W-1:0] left_s1;
	logic signed [SRC_W-1:0] right_s1;
	logic signed [OUT_W-1:0] prior_l_s1;
	logic signed [OUT_W-1:0] prior_r_s1;
	logic                    last_s1;

	logic                    valid_s2;
	logic signed [OUT_W-1:0] left_s2;
	logic signed [OUT_W-1:0] right_s2;
	logic                    last_s2;

	logic                    adv_s2;
	logic                    adv_s1;
	logic                    src_take;
	logic signed [SRC_W-1:0] right_src;
	logic signed [OUT_W-1:0] left_res;
	logic signed [OUT_W-1:0] right_res;

	ssmix_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Flow control: result register frees when empty or taken
	assign adv_s2    = !valid_s2 || !out_stall;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign src_stall = !adv_s1;
	assign src_take  = src_valid && !src_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_take) begin
			left_s1    <= src_left;
			right_s1   <= src_right;
			prior_l_s1 <= prior_left;
			prior_r_s1 <= prior_right;
			last_s1    <= end_of_block;
		end
	end

	// Decode format; the spare code behaves as stereo-wide
	always_comb begin
		ctrl.add_mode = cfg.add;
		unique case (cfg.fmt)
			FMT_STEREO: begin
				ctrl.vol_mode = 1'b0;
				right_src     = right_s1;
			end
			FMT_MONO: begin
				ctrl.vol_mode = 1'b0;
				right_src     = left_s1;
			end
			FMT_VOLUME: begin
				ctrl.vol_mode = 1'b1;
				right_src     = right_s1;
			end
			FMT_SPARE: begin
				ctrl.vol_mode = 1'b0;
				right_src     = right_s1;
			end
			default: begin
				ctrl.vol_mode = 1'b0;
				right_src     = right_s1;
			end
		endcase
	end

	ssmix_chan u_chan_l (
		.sample (left_s1),
		.prior  (prior_l_s1),
		.volume (cfg.vol_l),
		.ctrl   (ctrl),
		.result (left_res)
	);

	ssmix_chan u_chan_r (
		.sample (right_src),
		.prior  (prior_r_s1),
		.volume (cfg.vol_r),
		.ctrl   (ctrl),
		.result (right_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			left_s2  <= left_res;
			right_s2 <= right_res;
			last_s2  <= last_s1;
		end
	end

	assign out_valid  = valid_s2;
	assign out_left   = left_s2;
	assign out_right  = right_s2;
	assign block_last = last_s2;

	`ASSERT_CLK(a_stall_full, src_stall |-> valid_s1 && valid_s2 && out_stall, "source stalled with room in the pipeline")
	`ASSERT_CLK(a_take_s1, src_take |=> valid_s1, "accepted item not held in input register")
	`ASSERT_CLK(a_move_s2, valid_s1 && adv_s2 |=> valid_s2, "item lost between input and result register")
	`ASSERT_NEVER(a_s1_drop, valid_s1 && !adv_s1 && src_take, "input register overwritten while blocked")

endmodule
